// ----- src/segment_polygon_collision_defines.svh -----
// ----------------------------------------------------------------------------
// Segment/polygon collision: assertion macros
// Shared property forms for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_POLYGON_COLLISION_DEFINES_SVH
`define SEGMENT_POLYGON_COLLISION_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/spc_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment/polygon collision package
// Widths, op codes and the beat structs shared by the top and the edge tester.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spc_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 16;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int ACC_W        = PROD_W + 1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef struct packed {
    logic                      last;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vertex_t;

  localparam int VERT_W = $bits(vertex_t);

  typedef struct packed {
    logic                      zero;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
  } seg_t;

  typedef struct packed {
    logic                      vld;
    logic                      commit;
    logic signed [COORD_W-1:0] x3;
    logic signed [COORD_W-1:0] y3;
    logic signed [COORD_W-1:0] x4;
    logic signed [COORD_W-1:0] y4;
  } edge_req_t;

  typedef struct packed {
    logic vld;
    logic commit;
    logic meet;
  } edge_rsp_t;

  typedef struct packed {
    logic vld;
    logic commit;
  } tag_t;

endpackage

`default_nettype wire

// ----- src/spc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/spc_edge_test.sv -----
// ----------------------------------------------------------------------------
// Segment/edge intersection pipeline
// Four stages: differences, products, cross sums, exact unit-range checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spc_edge_test import spc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire edge_req_t req,
  input  wire seg_t      seg,
  output edge_rsp_t      rsp,
  output logic           pipe_busy
);

  tag_t tag1_r, tag2_r, tag3_r;
  logic ok1_r, ok2_r, ok3_r;
  logic signed [DIFF_W-1:0] ex1_r, ey1_r, rx1_r, ry1_r;
  logic signed [DIFF_W-1:0] dx1_r, dy1_r;
  logic signed [PROD_W-1:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  logic signed [ACC_W-1:0]  den3_r, na3_r, nb3_r;
  edge_rsp_t                rsp_r;

  logic signed [DIFF_W-1:0] ex, ey, rx, ry;
  logic                     ok1_nxt, meet_nxt;

  function automatic logic in_unit(input logic signed [ACC_W-1:0] num,
                                   input logic signed [ACC_W-1:0] den);
    if (den > 0) begin
      return (num >= 0) && (num <= den);
    end
    return (num <= 0) && (num >= den);
  endfunction

  always_comb begin
    ex       = DIFF_W'(req.x4) - DIFF_W'(req.x3);
    ey       = DIFF_W'(req.y4) - DIFF_W'(req.y3);
    rx       = DIFF_W'(seg.ax) - DIFF_W'(req.x3);
    ry       = DIFF_W'(seg.ay) - DIFF_W'(req.y3);
    ok1_nxt  = req.vld && !seg.zero && !((ex == '0) && (ey == '0));
    meet_nxt = ok3_r && (den3_r != '0) && in_unit(na3_r, den3_r)
               && in_unit(nb3_r, den3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
      rsp_r  <= '0;
    end else begin
      tag1_r <= '{vld: req.vld, commit: req.commit};
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      rsp_r  <= '{vld: tag3_r.vld, commit: tag3_r.commit, meet: meet_nxt};
    end
  end

  always_ff @(posedge clk) begin
    ok1_r  <= ok1_nxt;
    ex1_r  <= ex;
    ey1_r  <= ey;
    rx1_r  <= rx;
    ry1_r  <= ry;
    dx1_r  <= seg.dx;
    dy1_r  <= seg.dy;
    ok2_r  <= ok1_r;
    p1_r   <= ey1_r * dx1_r;
    p2_r   <= ex1_r * dy1_r;
    p3_r   <= ex1_r * ry1_r;
    p4_r   <= ey1_r * rx1_r;
    p5_r   <= dx1_r * ry1_r;
    p6_r   <= dy1_r * rx1_r;
    ok3_r  <= ok2_r;
    den3_r <= ACC_W'(p1_r) - ACC_W'(p2_r);
    na3_r  <= ACC_W'(p3_r) - ACC_W'(p4_r);
    nb3_r  <= ACC_W'(p5_r) - ACC_W'(p6_r);
  end

  assign rsp       = rsp_r;
  assign pipe_busy = tag1_r.vld || tag1_r.commit || tag2_r.vld || tag2_r.commit
                     || tag3_r.vld || tag3_r.commit || rsp_r.vld || rsp_r.commit;

endmodule

`default_nettype wire

// ----- src/segment_polygon_collision.sv -----
// ----------------------------------------------------------------------------
// Segment/polygon collision tester
// Stores polygon vertices in a RAM and tests a query segment against all edges.
// ----------------------------------------------------------------------------
// Usage: drive in_op and the payload with start; a command is taken at a clock
// edge with start high and busy low. Clear (op 0), append (op 1) and the unused
// op 3 finish at once: out_valid pulses in the cycle after the beat and busy
// stays low, so commands can be issued back to back. Append to a full store
// (256 vertices) drops the vertex and returns out_status = 1.
// A query (op 2) raises busy and walks the vertex RAM one entry per cycle
// through its single read port, pausing the reads for the closing edge of
// each finished polygon of two or more vertices. Each edge enters a four-stage
// intersection pipeline. Once the last edge result is folded in, out_valid
// pulses for one cycle with out_hit, and busy drops in that same cycle.
// Results are never held off; each beat is on the out_ ports for one cycle.
// Reset empties the store (vertex count 0) and returns the block to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segment_polygon_collision import spc_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                in_op,
  input  wire logic signed [COORD_W-1:0] in_vert_x,
  input  wire logic signed [COORD_W-1:0] in_vert_y,
  input  wire logic                      in_closes_polygon,
  input  wire logic signed [COORD_W-1:0] in_seg_a_x,
  input  wire logic signed [COORD_W-1:0] in_seg_a_y,
  input  wire logic signed [COORD_W-1:0] in_seg_b_x,
  input  wire logic signed [COORD_W-1:0] in_seg_b_y,
  output logic                           out_valid,
  output logic                           out_hit,
  output logic                           out_status
);

`include "segment_polygon_collision_defines.svh"

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t    state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] addr_r, addr_nxt;
  logic      dout_vld_r, dout_vld_nxt;
  logic      close_r, close_nxt;
  logic      first_pend_r, first_pend_nxt;
  logic      hit_r, hit_nxt;
  logic      poly_hit_r, poly_hit_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      out_hit_r, out_hit_nxt;
  logic      out_status_r, out_status_nxt;
  vertex_t   prev_r, prev_nxt;
  vertex_t   first_r, first_nxt;
  seg_t      seg_r, seg_nxt;
  edge_req_t ereq_r, ereq_nxt;

  logic              accept, we, re, stall, issue;
  logic [VERT_W-1:0] rdata;
  vertex_t           wvert, vtx;
  edge_rsp_t         ersp;
  logic              pipe_busy;
  logic signed [DIFF_W-1:0] sdx, sdy;

  assign accept = start && !busy;
  assign wvert  = '{last: in_closes_polygon, x: in_vert_x, y: in_vert_y};
  assign vtx    = vertex_t'(rdata);
  assign sdx    = DIFF_W'(in_seg_b_x) - DIFF_W'(in_seg_a_x);
  assign sdy    = DIFF_W'(in_seg_b_y) - DIFF_W'(in_seg_a_y);
  assign stall  = dout_vld_r && vtx.last && !first_pend_r;
  assign issue  = (state_r == ST_WALK) && (addr_r < cnt_r) && !stall;

  spc_ram #(
    .WIDTH (VERT_W),
    .DEPTH (MAX_VERTICES)
  ) u_vert_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (wvert),
    .re    (re),
    .raddr (addr_r[ADDR_W-1:0]),
    .rdata (rdata)
  );

  spc_edge_test u_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (ereq_r),
    .seg       (seg_r),
    .rsp       (ersp),
    .pipe_busy (pipe_busy)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    addr_nxt       = addr_r;
    dout_vld_nxt   = 1'b0;
    close_nxt      = 1'b0;
    first_pend_nxt = first_pend_r;
    hit_nxt        = hit_r;
    poly_hit_nxt   = poly_hit_r;
    out_valid_nxt  = 1'b0;
    out_hit_nxt    = 1'b0;
    out_status_nxt = 1'b0;
    prev_nxt       = prev_r;
    first_nxt      = first_r;
    seg_nxt        = seg_r;
    ereq_nxt       = ereq_r;
    ereq_nxt.vld   = 1'b0;
    ereq_nxt.commit = 1'b0;
    we             = 1'b0;
    re             = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_CLEAR: begin
              cnt_nxt       = '0;
              out_valid_nxt = 1'b1;
            end
            OP_APPEND: begin
              out_valid_nxt = 1'b1;
              if (cnt_r < CNT_W'(MAX_VERTICES)) begin
                we      = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end else begin
                out_status_nxt = 1'b1;
              end
            end
            OP_QUERY: begin
              state_nxt      = ST_WALK;
              addr_nxt       = '0;
              first_pend_nxt = 1'b1;
              hit_nxt        = 1'b0;
              poly_hit_nxt   = 1'b0;
              seg_nxt        = '{zero: (sdx == '0) && (sdy == '0),
                                 ax: in_seg_a_x, ay: in_seg_a_y, dx: sdx, dy: sdy};
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        // issue the next RAM read unless the closing edge needs this cycle
        re           = issue;
        dout_vld_nxt = issue;
        if (issue) begin
          addr_nxt = addr_r + 1'b1;
        end

        // turn the vertex stream into edges
        if (close_r) begin
          ereq_nxt = '{vld: 1'b1, commit: 1'b1, x3: prev_r.x, y3: prev_r.y,
                       x4: first_r.x, y4: first_r.y};
        end else if (dout_vld_r) begin
          prev_nxt = vtx;
          if (first_pend_r) begin
            first_nxt = vtx;
            if (vtx.last) begin
              ereq_nxt.commit = 1'b1;
            end else begin
              first_pend_nxt = 1'b0;
            end
          end else begin
            ereq_nxt = '{vld: 1'b1, commit: 1'b0, x3: prev_r.x, y3: prev_r.y,
                         x4: vtx.x, y4: vtx.y};
            if (vtx.last) begin
              close_nxt      = 1'b1;
              first_pend_nxt = 1'b1;
            end
          end
        end

        // fold edge results; a polygon counts only once it is closed
        if (ersp.commit) begin
          hit_nxt      = hit_r || poly_hit_r || (ersp.vld && ersp.meet);
          poly_hit_nxt = 1'b0;
        end else if (ersp.vld) begin
          poly_hit_nxt = poly_hit_r || ersp.meet;
        end

        if ((addr_r == cnt_r) && !dout_vld_r && !close_r && !ereq_r.vld
            && !ereq_r.commit && !pipe_busy) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      addr_r       <= '0;
      dout_vld_r   <= 1'b0;
      close_r      <= 1'b0;
      first_pend_r <= 1'b1;
      hit_r        <= 1'b0;
      poly_hit_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      out_hit_r    <= 1'b0;
      out_status_r <= 1'b0;
      ereq_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      addr_r       <= addr_nxt;
      dout_vld_r   <= dout_vld_nxt;
      close_r      <= close_nxt;
      first_pend_r <= first_pend_nxt;
      hit_r        <= hit_nxt;
      poly_hit_r   <= poly_hit_nxt;
      out_valid_r  <= out_valid_nxt;
      out_hit_r    <= out_hit_nxt;
      out_status_r <= out_status_nxt;
      ereq_r       <= ereq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r    <= prev_nxt;
    first_r   <= first_nxt;
    seg_r     <= seg_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_hit    = out_hit_r;
  assign out_status = out_status_r;

  `SPC_ASSERT_NEXT(a_quick_result, accept && (in_op != OP_QUERY), out_valid, "non-query beat gave no result")
  `SPC_ASSERT_NOW(a_count_range, 1'b1, cnt_r <= CNT_W'(MAX_VERTICES), "vertex count past store depth")
  `SPC_ASSERT_NOW(a_close_stall, close_r, !dout_vld_r, "RAM read issued during closing edge")
  `SPC_ASSERT_NOW(a_full_no_hit, out_valid && out_status, !out_hit, "hit reported on dropped vertex")

endmodule

`default_nettype wire
